// ===== hdl/qafrp_pkg.sv =====
// Shared types and constants for the ACK frame range parser.
// Holds the item and result structs, the parse phase codes and the status codes.
// No dependencies; every other file imports this package.
`default_nettype none

package qafrp_pkg;

    // Stream widths on the top-level ports.
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 192;
    localparam int M_TUSER_W = 5;

    // Parse phases. The phase code of a field doubles as its truncation status.
    localparam logic [2:0] PH_TYPE    = 3'd0;
    localparam logic [2:0] PH_LARGEST = 3'd1;
    localparam logic [2:0] PH_DELAY   = 3'd2;
    localparam logic [2:0] PH_COUNT   = 3'd3;
    localparam logic [2:0] PH_FIRST   = 3'd4;
    localparam logic [2:0] PH_GAP     = 3'd5;
    localparam logic [2:0] PH_RANGE   = 3'd6;

    // Result status codes.
    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_TRUNC_LARGEST = 3'd1;
    localparam logic [2:0] ST_TRUNC_DELAY   = 3'd2;
    localparam logic [2:0] ST_TRUNC_COUNT   = 3'd3;
    localparam logic [2:0] ST_TRUNC_FIRST   = 3'd4;
    localparam logic [2:0] ST_TRUNC_GAP     = 3'd5;
    localparam logic [2:0] ST_TRUNC_RANGE   = 3'd6;

    // One input byte with its side information.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
        logic [1:0] number_space;
    } in_item_t;

    // One acknowledged range or status word.
    typedef struct packed {
        logic [63:0] range_high;
        logic [63:0] range_low;
        logic [61:0] delay_field;
        logic [1:0]  space_echo;
        logic        last_range;
        logic [2:0]  status;
    } result_t;

    // Parser output toward the result register.
    typedef struct packed {
        logic    emit;
        result_t result;
    } parse_out_t;

endpackage

`default_nettype wire

// ===== hdl/qafrp_in_stage.sv =====
// Input register of the range parser: holds one accepted byte until the parser consumes it.
// Depends on qafrp_pkg for the input item type.
`default_nettype none

module qafrp_in_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire qafrp_pkg::in_item_t s_item,
    input  wire logic               advance,
    output logic                    item_valid,
    output qafrp_pkg::in_item_t     item
);
    import qafrp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     take;

    // The register frees up in the same cycle that the parser consumes its word.
    assign s_ready = !valid_reg || advance;
    assign take    = s_valid && s_ready;

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== hdl/qafrp_parser.sv =====
// Frame parser of the range parser: phase state, varint assembly and range arithmetic.
// Consumes one byte per cycle when go is high; depends on qafrp_pkg.
`default_nettype none

module qafrp_parser (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                go,
    input  wire qafrp_pkg::in_item_t item,
    output qafrp_pkg::parse_out_t    pout
);
    import qafrp_pkg::*;

    logic [2:0]  phase_reg,     phase_next;
    logic [61:0] accum_reg,     accum_next;
    logic [2:0]  left_reg,      left_next;
    logic [61:0] delay_reg,     delay_next;
    logic [61:0] count_reg,     count_next;
    logic [63:0] prev_low_reg,  prev_low_next;
    logic [63:0] next_high_reg, next_high_next;

    logic [61:0] acc;
    logic [2:0]  left_new;
    logic [61:0] count_dec;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] v64;
    logic        have_range;
    logic [2:0]  phase_done;

    // Assemble the next varint byte: a first byte carries the length code.
    always_comb
    begin
        if (left_reg == 3'd0)
        begin
            acc = {56'd0, item.data_byte[5:0]};
            case (item.data_byte[7:6])
                2'd0:    left_new = 3'd0;
                2'd1:    left_new = 3'd1;
                2'd2:    left_new = 3'd3;
                default: left_new = 3'd7;
            endcase
        end
        else
        begin
            acc      = {accum_reg[53:0], item.data_byte};
            left_new = left_reg - 3'd1;
        end
    end

    assign v64       = {2'b00, acc};
    assign count_dec = count_reg - 62'd1;
    assign lo        = next_high_reg - v64;

    // Next state and result for the byte in the input register.
    always_comb
    begin
        phase_next     = phase_reg;
        accum_next     = accum_reg;
        left_next      = left_reg;
        delay_next     = delay_reg;
        count_next     = count_reg;
        prev_low_next  = prev_low_reg;
        next_high_next = next_high_reg;
        hi             = 64'd0;
        have_range     = 1'b0;
        phase_done     = phase_reg;

        pout                   = '0;
        pout.result.space_echo = item.number_space;

        if (phase_reg == PH_TYPE || phase_reg > PH_RANGE)
        begin
            // Type byte: start a fresh frame.
            accum_next     = '0;
            left_next      = '0;
            delay_next     = '0;
            count_next     = '0;
            prev_low_next  = '0;
            next_high_next = '0;
            if (item.buffer_end)
            begin
                phase_next             = PH_TYPE;
                pout.emit              = 1'b1;
                pout.result.last_range = 1'b1;
                pout.result.status     = ST_TRUNC_LARGEST;
            end
            else
            begin
                phase_next = PH_LARGEST;
            end
        end
        else
        begin
            accum_next = acc;
            left_next  = left_new;
            if (left_new != 3'd0)
            begin
                // Field still incomplete.
                if (item.buffer_end)
                begin
                    phase_next              = PH_TYPE;
                    left_next               = 3'd0;
                    pout.emit               = 1'b1;
                    pout.result.delay_field = delay_reg;
                    pout.result.last_range  = 1'b1;
                    pout.result.status      = phase_reg;
                end
            end
            else
            begin
                // Field complete: act on its value.
                case (phase_reg)
                    PH_LARGEST:
                    begin
                        next_high_next = v64;
                        phase_done     = PH_DELAY;
                    end
                    PH_DELAY:
                    begin
                        delay_next = acc;
                        phase_done = PH_COUNT;
                    end
                    PH_COUNT:
                    begin
                        count_next = acc;
                        phase_done = PH_FIRST;
                    end
                    PH_FIRST:
                    begin
                        hi            = next_high_reg;
                        prev_low_next = lo;
                        have_range    = 1'b1;
                        phase_done    = (count_reg == 62'd0) ? PH_TYPE : PH_GAP;
                    end
                    PH_GAP:
                    begin
                        // Precompute the next range's high end from the gap.
                        next_high_next = prev_low_reg - v64 - 64'd2;
                        phase_done     = PH_RANGE;
                    end
                    default:
                    begin
                        hi            = next_high_reg;
                        prev_low_next = lo;
                        count_next    = count_dec;
                        have_range    = 1'b1;
                        phase_done    = (count_dec == 62'd0) ? PH_TYPE : PH_GAP;
                    end
                endcase

                phase_next              = item.buffer_end ? PH_TYPE : phase_done;
                pout.result.delay_field = delay_next;
                pout.result.range_high  = have_range ? hi : 64'd0;
                pout.result.range_low   = have_range ? lo : 64'd0;

                if (item.buffer_end && phase_done != PH_TYPE)
                begin
                    // Buffer ran out between fields: name the field that was due.
                    pout.emit              = 1'b1;
                    pout.result.last_range = 1'b1;
                    pout.result.status     = phase_done;
                end
                else if (have_range)
                begin
                    pout.emit              = 1'b1;
                    pout.result.last_range = (phase_done == PH_TYPE);
                    pout.result.status     = ST_OK;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TYPE;
            accum_reg     <= '0;
            left_reg      <= '0;
            delay_reg     <= '0;
            count_reg     <= '0;
            prev_low_reg  <= '0;
            next_high_reg <= '0;
        end
        else if (go)
        begin
            phase_reg     <= phase_next;
            accum_reg     <= accum_next;
            left_reg      <= left_next;
            delay_reg     <= delay_next;
            count_reg     <= count_next;
            prev_low_reg  <= prev_low_next;
            next_high_reg <= next_high_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/qafrp_out_stage.sv =====
// Result register of the range parser: holds one result word until the sink takes it.
// Depends on qafrp_pkg for the result type.
`default_nettype none

module qafrp_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire qafrp_pkg::result_t result_in,
    output logic                   free,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output qafrp_pkg::result_t     result_out
);
    import qafrp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // A new word may land in the same cycle the held one is taken.
    assign free = !valid_reg || m_ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign m_valid    = valid_reg;
    assign result_out = result_reg;

endmodule

`default_nettype wire

// ===== hdl/quic_ack_frame_range_parser_core.sv =====
// Top level of the ACK frame range parser: input register, parser and result register.
// Depends on qafrp_pkg, qafrp_in_stage, qafrp_parser and qafrp_out_stage.
//
// The parser takes one byte of an ACK frame per clock while the result register can take
// a word, and then runs with no gaps; an accepted byte sits in the input register while
// the parser works on it, and its result word, if any, is loaded into the result register
// and shown on the master side from there. The only loop is the
// parser's state update, one short shift, add and compare per byte. The first byte of a
// frame is the type byte and is skipped; then the varint fields are read and each
// completed range field yields one word on the master side with the range's high and
// low packet numbers. tlast on the slave side marks the last byte in the buffer; tlast
// on the master side marks the final range of a frame or a truncation, and the status in
// tuser names the field that was cut short.
`default_nettype none

module quic_ack_frame_range_parser_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [7:0] data_byte
    input  wire logic [qafrp_pkg::S_TDATA_W-1:0]  s_tdata,
    // buffer_end
    input  wire logic                             s_tlast,
    // [1:0] number_space
    input  wire logic [qafrp_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [63:0] range_high, [127:64] range_low, [189:128] delay_field, [191:190] zero
    output logic [qafrp_pkg::M_TDATA_W-1:0]       m_tdata,
    // last_range
    output logic                                  m_tlast,
    // [1:0] space_echo, [4:2] status
    output logic [qafrp_pkg::M_TUSER_W-1:0]       m_tuser
);
    import qafrp_pkg::*;

    in_item_t   s_item;
    in_item_t   item;
    logic       item_valid;
    logic       out_free;
    logic       advance;
    parse_out_t pout;
    result_t    res;

    assign s_item.data_byte    = s_tdata;
    assign s_item.buffer_end   = s_tlast;
    assign s_item.number_space = s_tuser;

    // The parser moves whenever a byte is held and the result register can take a word.
    assign advance = item_valid && out_free;

    qafrp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    qafrp_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (advance),
        .item  (item),
        .pout  (pout)
    );

    qafrp_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && pout.emit),
        .result_in  (pout.result),
        .free       (out_free),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .result_out (res)
    );

    // Pack the result word onto the master side.
    assign m_tdata = {2'b00, res.delay_field, res.range_low, res.range_high};
    assign m_tlast = res.last_range;
    assign m_tuser = {res.status, res.space_echo};

endmodule

`default_nettype wire

// ===== hdl/qafrp_checker.sv =====
// Port-level checks for the ACK frame range parser, bound to the top level.
// Depends on qafrp_pkg and on quic_ack_frame_range_parser_core.
`default_nettype none

module qafrp_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [qafrp_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic                             m_tlast,
    input wire logic [qafrp_pkg::M_TUSER_W-1:0]  m_tuser
);
    import qafrp_pkg::*;

    // A held result word does not change while the sink stalls.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result word changed while stalled");

    // Any truncation status ends the frame.
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[4:2] != ST_OK |-> m_tlast)
        else $error("truncation result without last flag");

    // Status codes stop at the range field.
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser[4:2] <= ST_TRUNC_RANGE)
        else $error("status code out of range");

    // Before the first range completes, no range values can be reported.
    a_no_range_early: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[4:2] == ST_TRUNC_LARGEST || m_tuser[4:2] == ST_TRUNC_DELAY
                     || m_tuser[4:2] == ST_TRUNC_COUNT || m_tuser[4:2] == ST_TRUNC_FIRST)
        |-> m_tdata[127:0] == 128'd0)
        else $error("range values reported before the first range");

    // The delay is not yet known while the largest or delay field is pending.
    a_no_delay_early: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[4:2] == ST_TRUNC_LARGEST || m_tuser[4:2] == ST_TRUNC_DELAY)
        |-> m_tdata[189:128] == 62'd0)
        else $error("ack delay reported before it was decoded");

endmodule

bind quic_ack_frame_range_parser_core qafrp_checker u_qafrp_checker (.*);

`default_nettype wire
